@@ hw/rtl/animation_playhead_controller_defines.svh @@
// assertion macros shared by the playhead controller rtl
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef ANIMATION_PLAYHEAD_CONTROLLER_DEFINES_SVH
`define ANIMATION_PLAYHEAD_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
`define APC_ASSERT_HOLDS(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apc assertion failed");
`define APC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apc assertion failed");
`else
`define APC_ASSERT_HOLDS(label, ante, cons)
`define APC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ hw/rtl/apc_pkg.sv @@
// widths, codes and shared types of the animation playhead controller
// no dependencies
package apc_pkg;

    localparam int TIME_W          = 32;
    localparam int SPEED_W         = 16;
    localparam int SPEED_FRAC_BITS = 8;
    localparam int PROD_W          = TIME_W + SPEED_W;
    localparam int ADV_W           = PROD_W - SPEED_FRAC_BITS;
    localparam int CYC_W           = TIME_W + 1;
    localparam int NEXT_W          = ((ADV_W > CYC_W) ? ADV_W : CYC_W) + 1;
    localparam int MOD_CNT_W       = $clog2(NEXT_W + 1);
    localparam int OP_W            = 3;
    localparam int MODE_W          = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = TIME_W;

    localparam logic [MODE_W-1:0] MODE_ONCE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOP = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_DURATION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_FACTOR  = 2'd2;

    localparam logic [MODE_W-1:0]  PLAY_MODE_RESET     = MODE_ONCE;
    localparam logic [TIME_W-1:0]  CLIP_DURATION_RESET = 32'h0001_0000;
    localparam logic [SPEED_W-1:0] SPEED_FACTOR_RESET  = 16'h0100;

    typedef enum logic [OP_W-1:0] {
        OP_UPDATE  = 3'd0,
        OP_PLAY    = 3'd1,
        OP_PAUSE   = 3'd2,
        OP_RESTART = 3'd3,
        OP_STOP    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_ADD,
        ST_MOD,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_stat_t;

endpackage

@@ hw/rtl/apc_mod_unit.sv @@
// bit-serial restoring remainder unit, one dividend bit per cycle
// depends on apc_pkg
module apc_mod_unit
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [apc_pkg::NEXT_W-1:0] dividend,
    input  logic [apc_pkg::CYC_W-1:0]  divisor,
    output logic [apc_pkg::CYC_W-1:0]  remainder,
    output apc_pkg::mod_stat_t         stat
);

    logic [apc_pkg::NEXT_W-1:0]    dvd_reg, dvd_next;
    logic [apc_pkg::CYC_W-1:0]     dsr_reg, dsr_next;
    logic [apc_pkg::CYC_W-1:0]     rem_reg, rem_next;
    logic [apc_pkg::MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [apc_pkg::CYC_W:0]       rem_sh;
    logic [apc_pkg::CYC_W+1:0]     diff;

    always_comb
    begin
        rem_sh    = {rem_reg, dvd_reg[apc_pkg::NEXT_W-1]};
        diff      = {1'b0, rem_sh} - {2'b00, dsr_reg};
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = apc_pkg::MOD_CNT_W'(apc_pkg::NEXT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[apc_pkg::NEXT_W-2:0], 1'b0};
            // keep the shifted remainder when the trial subtract borrows
            rem_next = diff[apc_pkg::CYC_W+1] ? rem_sh[apc_pkg::CYC_W-1:0]
                                              : diff[apc_pkg::CYC_W-1:0];
            cnt_next = cnt_reg - apc_pkg::MOD_CNT_W'(1);
            if (cnt_reg == apc_pkg::MOD_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign remainder = rem_reg;
    assign stat      = {busy_reg, done_reg};

endmodule

@@ hw/rtl/animation_playhead_controller.sv @@
// animation playhead controller: sequencer, playhead state and result register
// depends on apc_pkg, apc_mod_unit and animation_playhead_controller_defines.svh
//
// usage
//   s_axis carries one operation per transaction: tuser holds the op code,
//   tdata the elapsed time (Q16.16) for an update. m_axis returns exactly one
//   result per operation: previous and current playhead time in tdata and the
//   status flags in tuser.
//   cfg_we/cfg_index/cfg_data write play mode, clip duration and speed; write
//   them only while no operation is in flight.
//   a non-update op, or an update that does not run, goes straight to the result
//   state; a once-mode update first passes the multiply and add states; a loop
//   or ping-pong update with a nonzero duration also waits in the mod state for
//   the bit-serial remainder unit, stepping through the 41-bit next position
//   one bit per cycle. s_axis_tready is high only while idle, so no op is taken
//   until the last is done; the next may be taken while the last result waits.
//   if the receiver stalls, the finished result is held in the output register
//   and a following result waits in the sequencer until it drains.
//   reset: config returns to once mode, one second, speed 1.0; the playhead is
//   at zero, playing and not completed.
`include "animation_playhead_controller_defines.svh"

module animation_playhead_controller
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [apc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [apc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,  // [31:0] delta_time
    input  logic [2:0]                      s_axis_tuser,  // [2:0] op
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [63:0]                     m_axis_tdata,  // [31:0] previous_time,
                                                           // [63:32] current_time
    output logic [3:0]                      m_axis_tuser   // [0] pose_changed,
                                                           // [1] completed_now,
                                                           // [2] is_playing,
                                                           // [3] is_completed
);

    localparam int TW = apc_pkg::TIME_W;
    localparam int CW = apc_pkg::CYC_W;
    localparam int NW = apc_pkg::NEXT_W;

    logic [apc_pkg::MODE_W-1:0]  play_mode_reg;
    logic [TW-1:0]               clip_duration_reg;
    logic [apc_pkg::SPEED_W-1:0] speed_factor_reg;

    apc_pkg::state_t             state_reg, state_next;
    logic [TW-1:0]               delta_reg, delta_next;
    logic [apc_pkg::PROD_W-1:0]  product_reg, product_next;
    logic [CW-1:0]               cycle_position_reg, cycle_position_next;
    logic [TW-1:0]               playhead_time_reg, playhead_time_next;
    logic                        playing_flag_reg, playing_flag_next;
    logic                        completed_flag_reg, completed_flag_next;
    logic [TW-1:0]               res_prev_reg, res_prev_next;
    logic                        res_changed_reg, res_changed_next;
    logic                        res_done_now_reg, res_done_now_next;
    logic                        out_valid_reg, out_valid_next;
    logic [63:0]                 out_data_reg, out_data_next;
    logic [3:0]                  out_user_reg, out_user_next;

    logic                        in_accept;
    logic                        mod_start;
    logic [CW-1:0]               mod_divisor;
    logic [CW-1:0]               mod_rem;
    apc_pkg::mod_stat_t          mod_stat;
    logic [apc_pkg::ADV_W-1:0]   advance;
    logic [NW-1:0]               next_pos;
    logic                        reach_end;
    logic [TW-1:0]               mirror_time;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    // loop wraps at the duration, ping-pong (mode two or three) at twice it
    assign mod_divisor = (play_mode_reg == apc_pkg::MODE_LOOP) ? {1'b0, clip_duration_reg}
                                                               : {clip_duration_reg, 1'b0};

    assign advance   = product_reg[apc_pkg::PROD_W-1:apc_pkg::SPEED_FRAC_BITS];
    assign next_pos  = NW'(cycle_position_reg) + NW'(advance);
    assign reach_end = next_pos >= NW'(clip_duration_reg);

    // back half of the ping-pong cycle runs backwards
    always_comb
    begin
        if (mod_rem <= {1'b0, clip_duration_reg})
        begin
            mirror_time = mod_rem[TW-1:0];
        end
        else
        begin
            mirror_time = TW'(mod_divisor - mod_rem);
        end
    end

    apc_mod_unit u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (next_pos),
        .divisor   (mod_divisor),
        .remainder (mod_rem),
        .stat      (mod_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_mode_reg     <= apc_pkg::PLAY_MODE_RESET;
            clip_duration_reg <= apc_pkg::CLIP_DURATION_RESET;
            speed_factor_reg  <= apc_pkg::SPEED_FACTOR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                apc_pkg::REG_PLAY_MODE:
                begin
                    play_mode_reg <= cfg_data[apc_pkg::MODE_W-1:0];
                end
                apc_pkg::REG_CLIP_DURATION:
                begin
                    clip_duration_reg <= cfg_data[TW-1:0];
                end
                apc_pkg::REG_SPEED_FACTOR:
                begin
                    speed_factor_reg <= cfg_data[apc_pkg::SPEED_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        delta_next          = delta_reg;
        product_next        = product_reg;
        cycle_position_next = cycle_position_reg;
        playhead_time_next  = playhead_time_reg;
        playing_flag_next   = playing_flag_reg;
        completed_flag_next = completed_flag_reg;
        res_prev_next       = res_prev_reg;
        res_changed_next    = res_changed_reg;
        res_done_now_next   = res_done_now_reg;
        out_valid_next      = out_valid_reg && !m_axis_tready;
        out_data_next       = out_data_reg;
        out_user_next       = out_user_reg;
        mod_start           = 1'b0;
        s_axis_tready       = 1'b0;

        unique case (state_reg)
            apc_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    delta_next        = s_axis_tdata;
                    res_prev_next     = playhead_time_reg;
                    res_changed_next  = 1'b0;
                    res_done_now_next = 1'b0;
                    state_next        = apc_pkg::ST_RESULT;
                    unique case (apc_pkg::op_t'(s_axis_tuser))
                        apc_pkg::OP_UPDATE:
                        begin
                            if (playing_flag_reg && (s_axis_tdata != '0))
                            begin
                                state_next = apc_pkg::ST_MULT;
                            end
                        end
                        apc_pkg::OP_PLAY:
                        begin
                            playing_flag_next = 1'b1;
                            if (completed_flag_reg)
                            begin
                                playhead_time_next  = '0;
                                cycle_position_next = '0;
                                completed_flag_next = 1'b0;
                            end
                        end
                        apc_pkg::OP_PAUSE:
                        begin
                            playing_flag_next = 1'b0;
                        end
                        apc_pkg::OP_RESTART:
                        begin
                            playhead_time_next  = '0;
                            cycle_position_next = '0;
                            playing_flag_next   = 1'b1;
                            completed_flag_next = 1'b0;
                        end
                        apc_pkg::OP_STOP:
                        begin
                            playhead_time_next  = '0;
                            cycle_position_next = '0;
                            playing_flag_next   = 1'b0;
                            completed_flag_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            apc_pkg::ST_MULT:
            begin
                product_next = apc_pkg::PROD_W'(delta_reg) * apc_pkg::PROD_W'(speed_factor_reg);
                state_next   = apc_pkg::ST_ADD;
            end
            apc_pkg::ST_ADD:
            begin
                priority if (play_mode_reg == apc_pkg::MODE_ONCE)
                begin
                    if (reach_end)
                    begin
                        cycle_position_next = CW'(clip_duration_reg);
                        playhead_time_next  = clip_duration_reg;
                        playing_flag_next   = 1'b0;
                    end
                    else
                    begin
                        cycle_position_next = next_pos[CW-1:0];
                        playhead_time_next  = next_pos[TW-1:0];
                    end
                    completed_flag_next = reach_end;
                    res_done_now_next   = reach_end && !completed_flag_reg;
                    res_changed_next    = (reach_end ? clip_duration_reg : next_pos[TW-1:0])
                                          != res_prev_reg;
                    state_next          = apc_pkg::ST_RESULT;
                end
                else if (clip_duration_reg == '0)
                begin
                    cycle_position_next = '0;
                    playhead_time_next  = '0;
                    completed_flag_next = 1'b0;
                    res_changed_next    = res_prev_reg != '0;
                    state_next          = apc_pkg::ST_RESULT;
                end
                else
                begin
                    mod_start  = 1'b1;
                    state_next = apc_pkg::ST_MOD;
                end
            end
            apc_pkg::ST_MOD:
            begin
                if (mod_stat.done)
                begin
                    cycle_position_next = mod_rem;
                    completed_flag_next = 1'b0;
                    if (play_mode_reg == apc_pkg::MODE_LOOP)
                    begin
                        playhead_time_next = mod_rem[TW-1:0];
                        res_changed_next   = mod_rem[TW-1:0] != res_prev_reg;
                    end
                    else
                    begin
                        playhead_time_next = mirror_time;
                        res_changed_next   = mirror_time != res_prev_reg;
                    end
                    state_next = apc_pkg::ST_RESULT;
                end
            end
            apc_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {playhead_time_reg, res_prev_reg};
                    out_user_next  = {completed_flag_reg, playing_flag_reg,
                                      res_done_now_reg, res_changed_reg};
                    state_next     = apc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = apc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= apc_pkg::ST_IDLE;
            cycle_position_reg <= '0;
            playhead_time_reg  <= '0;
            playing_flag_reg   <= 1'b1;
            completed_flag_reg <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            cycle_position_reg <= cycle_position_next;
            playhead_time_reg  <= playhead_time_next;
            playing_flag_reg   <= playing_flag_next;
            completed_flag_reg <= completed_flag_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg        <= delta_next;
        product_reg      <= product_next;
        res_prev_reg     <= res_prev_next;
        res_changed_reg  <= res_changed_next;
        res_done_now_reg <= res_done_now_next;
        out_data_reg     <= out_data_next;
        out_user_reg     <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    `APC_ASSERT_HOLDS(a_completed_not_playing, completed_flag_reg, !playing_flag_reg)
    `APC_ASSERT_NEXT(a_busy_after_accept, in_accept, !s_axis_tready)
    `APC_ASSERT_HOLDS(a_mod_done_in_mod, mod_stat.done, state_reg == apc_pkg::ST_MOD)
    `APC_ASSERT_HOLDS(a_mod_busy_in_mod, mod_stat.busy, state_reg == apc_pkg::ST_MOD)

endmodule

@@ bench/animation_playhead_controller_tb.sv @@
// self-checking bench for animation_playhead_controller: directed and random operations
// against a playhead predictor, random idling on both streams and a long output hold
// depends on apc_pkg and the controller rtl
`timescale 1ns / 100ps

module animation_playhead_controller_tb;

    localparam int          CLK_HALF       = 5;
    localparam int          CYCLE_LIMIT    = 1_000_000;
    localparam int          PRINT_CAP      = 100;
    localparam int          GAP_MAX        = 19;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          NUM_PHASES     = 16;
    localparam int          PHASE_ITEMS    = 120;
    localparam logic [1:0]  MODE_PING_PONG = 2'd2;
    localparam logic [1:0]  MODE_SPARE     = 2'd3;  // decoded as ping-pong
    localparam logic [2:0]  OP_UNUSED_LO   = 3'd5;
    localparam logic [2:0]  OP_UNUSED_HI   = 3'd7;

    typedef struct {
        logic [31:0] prev_time;
        logic [31:0] cur_time;
        logic        pose_changed;
        logic        completed_now;
        logic        playing;
        logic        completed;
    } playhead_result_t;

    logic                           clk           = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           cfg_we        = 1'b0;
    logic [apc_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [apc_pkg::CFG_DATA_W-1:0] cfg_data      = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [31:0]                    s_axis_tdata  = '0;
    logic [2:0]                     s_axis_tuser  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [63:0]                    m_axis_tdata;
    logic [3:0]                     m_axis_tuser;

    // predictor copy of the playhead and its settings
    logic [apc_pkg::MODE_W-1:0]  pb_mode;
    logic [apc_pkg::TIME_W-1:0]  pb_duration;
    logic [apc_pkg::SPEED_W-1:0] pb_speed;
    logic [apc_pkg::CYC_W-1:0]   pb_cycle;
    logic [apc_pkg::TIME_W-1:0]  pb_time;
    logic                        pb_playing;
    logic                        pb_completed;

    playhead_result_t pending_results[$];

    int unsigned cycle_count     = 0;
    int unsigned mismatch_count  = 0;
    int unsigned ops_sent        = 0;
    int unsigned results_checked = 0;
    int unsigned settings_used   = 0;
    int unsigned hold_cnt        = 0;
    int unsigned rx_wait         = 0;
    bit          tx_gaps_on      = 1'b1;
    bit          rx_gaps_on      = 1'b1;

    animation_playhead_controller u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t: %s got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic playhead_result_t predict_playhead(input logic [2:0] op,
                                                          input logic [31:0] delta);
        playhead_result_t r;
        logic [47:0]      product;
        logic [63:0]      advance;
        logic [63:0]      next_pos;
        logic [63:0]      dur;
        logic [63:0]      span;
        logic [63:0]      wrapped;
        logic [63:0]      t;
        logic             finished;
        r.prev_time     = pb_time;
        r.pose_changed  = 1'b0;
        r.completed_now = 1'b0;
        case (op)
            apc_pkg::OP_UPDATE:
            begin
                if (pb_playing && delta != 0)
                begin
                    product  = 48'(delta) * 48'(pb_speed);
                    advance  = 64'(product >> apc_pkg::SPEED_FRAC_BITS);
                    next_pos = 64'(pb_cycle) + advance;
                    dur      = 64'(pb_duration);
                    finished = 1'b0;
                    if (pb_mode == apc_pkg::MODE_ONCE)
                    begin
                        if (next_pos >= dur)
                        begin
                            wrapped  = dur;
                            finished = 1'b1;
                        end
                        else
                            wrapped = next_pos;
                        t = wrapped;
                    end
                    else if (pb_mode == apc_pkg::MODE_LOOP)
                    begin
                        wrapped = (dur != 0) ? next_pos % dur : 64'd0;
                        t       = wrapped;
                    end
                    else
                    begin
                        // mirror the second half of the doubled cycle
                        span    = dur * 2;
                        wrapped = (span != 0) ? next_pos % span : 64'd0;
                        t       = (wrapped <= dur) ? wrapped : span - wrapped;
                    end
                    r.completed_now = !pb_completed && finished;
                    pb_cycle        = wrapped[apc_pkg::CYC_W-1:0];
                    pb_time         = t[apc_pkg::TIME_W-1:0];
                    pb_completed    = finished;
                    if (finished)
                        pb_playing = 1'b0;
                    r.pose_changed = r.prev_time != pb_time;
                end
            end
            apc_pkg::OP_PLAY:
            begin
                if (pb_completed)
                begin
                    pb_time      = '0;
                    pb_cycle     = '0;
                    pb_completed = 1'b0;
                end
                pb_playing = 1'b1;
            end
            apc_pkg::OP_PAUSE:
                pb_playing = 1'b0;
            apc_pkg::OP_RESTART, apc_pkg::OP_STOP:
            begin
                pb_time      = '0;
                pb_cycle     = '0;
                pb_completed = 1'b0;
                pb_playing   = (op == apc_pkg::OP_RESTART);
            end
            default: ;
        endcase
        r.cur_time  = pb_time;
        r.playing   = pb_playing;
        r.completed = pb_completed;
        return r;
    endfunction

    task automatic check_result();
        playhead_result_t want;
        results_checked++;
        if (pending_results.size() == 0)
        begin
            report_mismatch("unexpected result, tdata low", m_axis_tdata[31:0], '0);
            return;
        end
        want = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== want.prev_time)
            report_mismatch("previous_time", m_axis_tdata[31:0], want.prev_time);
        if (m_axis_tdata[63:32] !== want.cur_time)
            report_mismatch("current_time", m_axis_tdata[63:32], want.cur_time);
        if (m_axis_tuser[0] !== want.pose_changed)
            report_mismatch("pose_changed", 32'(m_axis_tuser[0]), 32'(want.pose_changed));
        if (m_axis_tuser[1] !== want.completed_now)
            report_mismatch("completed_now", 32'(m_axis_tuser[1]), 32'(want.completed_now));
        if (m_axis_tuser[2] !== want.playing)
            report_mismatch("is_playing", 32'(m_axis_tuser[2]), 32'(want.playing));
        if (m_axis_tuser[3] !== want.completed)
            report_mismatch("is_completed", 32'(m_axis_tuser[3]), 32'(want.completed));
    endtask

    // result side: check each transaction, then stall or hold off as asked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_result();
                rx_wait = rx_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                if (m_axis_tvalid)
                    rx_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_op(input logic [2:0] op, input logic [31:0] delta);
        int unsigned gap;
        gap = tx_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= delta;
        s_axis_tuser  <= op;
        forever
        begin
            @(posedge clk);
            if (s_axis_tready)
                break;
        end
        pending_results.insert(pending_results.size(), predict_playhead(op, delta));
        ops_sent++;
    endtask

    task automatic wait_idle(input int unsigned settle);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [apc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            apc_pkg::REG_PLAY_MODE:     pb_mode     = val[apc_pkg::MODE_W-1:0];
            apc_pkg::REG_CLIP_DURATION: pb_duration = val[apc_pkg::TIME_W-1:0];
            apc_pkg::REG_SPEED_FACTOR:  pb_speed    = val[apc_pkg::SPEED_W-1:0];
            default: ;
        endcase
        settings_used++;
    endtask

    // every op at reset settings: pause, completion, play-after-completion, stop
    task automatic test_op_codes();
        send_op(apc_pkg::OP_UPDATE, 32'h0000_0000);
        send_op(apc_pkg::OP_UPDATE, 32'h0000_4000);
        send_op(apc_pkg::OP_PAUSE, $urandom);
        send_op(apc_pkg::OP_UPDATE, 32'h0000_1000);
        send_op(apc_pkg::OP_PLAY, 32'h0000_0000);
        send_op(apc_pkg::OP_UPDATE, 32'hFFFF_FFFF);
        send_op(apc_pkg::OP_UPDATE, 32'h0000_0100);
        send_op(apc_pkg::OP_PLAY, 32'h0000_0000);
        send_op(apc_pkg::OP_UPDATE, 32'h0000_8000);
        send_op(apc_pkg::OP_STOP, 32'h0000_0000);
        send_op(apc_pkg::OP_PLAY, 32'h0000_0000);
        send_op(apc_pkg::OP_UPDATE, 32'h0000_2000);
        send_op(apc_pkg::OP_RESTART, 32'hFFFF_FFFF);
        send_op(OP_UNUSED_LO, 32'hFFFF_FFFF);
        send_op(3'(OP_UNUSED_LO + 1), 32'h5555_5555);
        send_op(OP_UNUSED_HI, 32'hAAAA_AAAA);
    endtask

    // advance that truncates to zero, also with the position already past the end
    task automatic test_truncated_advance();
        wait_idle(4);
        write_reg(apc_pkg::REG_SPEED_FACTOR, 32'd1);
        send_op(apc_pkg::OP_UPDATE, 32'h0000_00FF);
        send_op(apc_pkg::OP_UPDATE, 32'h0000_0200);
        wait_idle(4);
        write_reg(apc_pkg::REG_CLIP_DURATION, 32'd1);
        send_op(apc_pkg::OP_UPDATE, 32'h0000_0001);
        send_op(apc_pkg::OP_RESTART, 32'h0000_0000);
    endtask

    // zero clip length in every mode
    task automatic test_zero_duration();
        wait_idle(4);
        write_reg(apc_pkg::REG_CLIP_DURATION, 32'd0);
        write_reg(apc_pkg::REG_PLAY_MODE, 32'(apc_pkg::MODE_LOOP));
        write_reg(apc_pkg::REG_SPEED_FACTOR, 32'hFFFF);
        send_op(apc_pkg::OP_UPDATE, 32'h0001_2345);
        wait_idle(4);
        write_reg(apc_pkg::REG_PLAY_MODE, 32'(MODE_PING_PONG));
        send_op(apc_pkg::OP_UPDATE, 32'hFFFF_FFFF);
        wait_idle(4);
        write_reg(apc_pkg::REG_PLAY_MODE, 32'(MODE_SPARE));
        send_op(apc_pkg::OP_UPDATE, 32'h0000_0003);
        wait_idle(4);
        write_reg(apc_pkg::REG_PLAY_MODE, 32'(apc_pkg::MODE_ONCE));
        send_op(apc_pkg::OP_UPDATE, 32'h0000_0100);
        send_op(apc_pkg::OP_PLAY, 32'h0000_0000);
    endtask

    // mostly frame updates with random content, a few control ops and stray codes
    task automatic test_random_phases(input int first, input int last);
        logic [31:0] dur;
        logic [15:0] spd;
        logic [63:0] scaled;
        logic [2:0]  op;
        logic [31:0] delta;
        int unsigned roll;
        for (int p = first; p < last; p++)
        begin
            wait_idle(4);
            case (p % 5)
                0:       dur = 32'd1;
                1:       dur = 32'hFFFF_FFFF;
                2:       dur = 32'h0001_0000;
                3:       dur = $urandom_range(2, 32'h0008_0000);
                default: dur = ($urandom == 0) ? 32'd1 : $urandom;
            endcase
            case (p % 6)
                0:       spd = 16'd1;
                1:       spd = 16'hFFFF;
                2:       spd = 16'h0100;
                default: spd = 16'($urandom_range(1, 16'hFFFF));
            endcase
            write_reg(apc_pkg::REG_PLAY_MODE, 32'(p % 4));
            write_reg(apc_pkg::REG_CLIP_DURATION, dur);
            write_reg(apc_pkg::REG_SPEED_FACTOR, 32'(spd));
            tx_gaps_on = (p % 3) != 2;
            rx_gaps_on = (p % 4) != 3;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 80)
                    op = apc_pkg::OP_UPDATE;
                else if (roll < 85)
                    op = apc_pkg::OP_PLAY;
                else if (roll < 89)
                    op = apc_pkg::OP_PAUSE;
                else if (roll < 93)
                    op = apc_pkg::OP_RESTART;
                else if (roll < 96)
                    op = apc_pkg::OP_STOP;
                else
                    op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
                roll = $urandom_range(0, 99);
                // zero to three eighths of the clip per step, so ends and wraps come often
                scaled = (64'(dur) * 32 / 64'(spd)) * $urandom_range(0, 3);
                if (roll < 40)
                    delta = $urandom_range(0, 32'h0000_8000);
                else if (roll < 65)
                    delta = (scaled > 64'hFFFF_FFFF) ? $urandom : scaled[31:0];
                else if (roll < 80)
                    delta = $urandom;
                else if (roll < 90)
                    delta = $urandom_range(0, 32'hFF);
                else
                    delta = '0;
                send_op(op, delta);
            end
        end
    endtask

    // receiver holds off while updates keep coming, so the input side stalls
    task automatic test_backpressure();
        wait_idle(4);
        tx_gaps_on = 1'b0;
        hold_cnt   = HOLD_CYCLES;
        for (int i = 0; i < 16; i++)
            send_op((i % 5 == 4) ? apc_pkg::OP_PLAY : apc_pkg::OP_UPDATE,
                    $urandom_range(1, 32'h0002_0000));
    endtask

    initial
    begin
        pb_mode      = apc_pkg::PLAY_MODE_RESET;
        pb_duration  = apc_pkg::CLIP_DURATION_RESET;
        pb_speed     = apc_pkg::SPEED_FACTOR_RESET;
        pb_cycle     = '0;
        pb_time      = '0;
        pb_playing   = 1'b1;
        pb_completed = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_op_codes();
        test_truncated_advance();
        test_zero_duration();
        test_random_phases(0, NUM_PHASES / 2);
        test_backpressure();
        test_random_phases(NUM_PHASES / 2, NUM_PHASES);
        wait_idle(60);

        $display("covered %0d operations in all play modes, %0d results checked",
                 ops_sent, results_checked);
        $display("%0d register writes incl. zero and full-range clip lengths and speeds",
                 settings_used);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ animation_playhead_controller.f @@
+incdir+hw/rtl
hw/rtl/apc_pkg.sv
hw/rtl/apc_mod_unit.sv
hw/rtl/animation_playhead_controller.sv
bench/animation_playhead_controller_tb.sv
